// ===== rtl/thbc_pkg.sv =====
// Shared constants for the thermistor beta-equation temperature converter.
package thbc_pkg;

    localparam int SERIES_TERMS = 10;

    localparam int RES_W  = 24;
    localparam int REG_W  = 16;
    localparam int CELS_W = 16;
    localparam int STAT_W = 2;

    localparam int AX_W   = 32;
    localparam int DEN_W  = 25;
    localparam int Y_W    = 36;
    localparam int PROD_W = AX_W + Y_W;
    localparam int LN_W   = Y_W + 1;
    localparam int TM_W   = 38;
    localparam int RN_W   = 49;
    localparam int W_W    = 19;
    localparam int M_W    = 22;

    localparam logic [63:0] INV_T25_Q32 =
        ((64'd1 << 32) * 64'd20 + 64'd2981) / 64'd5963;
    localparam logic [RN_W-1:0] RECIP_NUM = RN_W'(5) << 46;
    localparam logic signed [50:0] ZERO_C_OFS = 51'sd22376448;
    localparam logic signed [50:0] HALF_DIV   = 51'sd640;
    localparam logic signed [50:0] SAT_SPAN   = 51'sd163840;
    localparam logic [M_W-1:0] DIV5_MUL = 22'd3355444;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

    localparam logic CFG_REF_RES = 1'b0;
    localparam logic CFG_BETA    = 1'b1;

endpackage

// ===== rtl/thermistor_beta_to_celsius_unit.sv =====
// Pipelined thermistor resistance to Celsius converter by the beta equation.
// One item is accepted every cycle while the output is not stalled;
// the three one-bit-per-stage dividers set the depth.
// The whole pipeline holds while a finished result waits at the output.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
module thermistor_beta_to_celsius_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // resistance[23:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // celsius[15:0]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int T = thbc_pkg::SERIES_TERMS;

    logic w_en;
    logic [15:0] r_ref, r_beta;
    logic [15:0] n_rref, n_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= 16'd120;
            r_beta <= 16'd3910;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                thbc_pkg::CFG_REF_RES: r_ref  <= i_cfg_data;
                thbc_pkg::CFG_BETA:    r_beta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_rref = (r_ref == 16'd0) ? 16'd1 : r_ref;
    assign n_beta = (r_beta == 16'd0) ? 16'd1 : r_beta;

    logic r_o_v;
    logic [15:0] r_o_c;
    logic [1:0]  r_o_st;

    assign w_en       = !r_o_v || i_m_tready;
    assign o_s_tready = w_en;

    // Ratio divider: x = |R - 256*Rref| / (R + 256*Rref), one bit per stage.
    logic                        r_x_v    [0:32];
    logic                        r_x_zero [0:32];
    logic                        r_x_neg  [0:32];
    logic [thbc_pkg::DEN_W-1:0]  r_x_den  [0:32];
    logic [thbc_pkg::DEN_W-1:0]  r_x_rem  [0:32];
    logic [thbc_pkg::AX_W-1:0]   r_x_q    [0:32];

    logic [23:0] n_sref;
    logic        n_neg;

    assign n_sref = {n_rref, 8'd0};
    assign n_neg  = i_s_tdata < n_sref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v[0] <= 1'b0;
        end else if (w_en) begin
            r_x_v[0] <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_zero[0] <= i_s_tdata == 24'd0;
            r_x_neg[0]  <= n_neg;
            r_x_den[0]  <= {1'b0, i_s_tdata} + {1'b0, n_sref};
            r_x_rem[0]  <= n_neg ? {1'b0, n_sref - i_s_tdata} : {1'b0, i_s_tdata - n_sref};
            r_x_q[0]    <= '0;
        end
    end

    for (genvar gi = 0; gi < 32; gi++) begin : g_xdiv
        logic [thbc_pkg::DEN_W:0] n_t;
        logic                     n_ge;
        assign n_t  = {r_x_rem[gi], 1'b0};
        assign n_ge = n_t >= {1'b0, r_x_den[gi]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_x_v[gi+1] <= 1'b0;
            end else if (w_en) begin
                r_x_v[gi+1] <= r_x_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x_zero[gi+1] <= r_x_zero[gi];
                r_x_neg[gi+1]  <= r_x_neg[gi];
                r_x_den[gi+1]  <= r_x_den[gi];
                r_x_rem[gi+1]  <= n_ge ? thbc_pkg::DEN_W'(n_t - {1'b0, r_x_den[gi]})
                                       : n_t[thbc_pkg::DEN_W-1:0];
                r_x_q[gi+1]    <= {r_x_q[gi][thbc_pkg::AX_W-2:0], n_ge};
            end
        end
    end

    // Series by Horner's rule: a multiply stage and an add stage per term.
    logic                       r_h_v    [0:T];
    logic                       r_h_zero [0:T];
    logic                       r_h_neg  [0:T];
    logic [thbc_pkg::AX_W-1:0]  r_h_ax   [0:T];
    logic [thbc_pkg::AX_W-1:0]  r_h_xx   [0:T];
    logic [thbc_pkg::Y_W-1:0]   r_h_y    [0:T];

    logic                        r_p_v    [1:T];
    logic                        r_p_zero [1:T];
    logic                        r_p_neg  [1:T];
    logic [thbc_pkg::AX_W-1:0]   r_p_ax   [1:T];
    logic [thbc_pkg::AX_W-1:0]   r_p_xx   [1:T];
    logic [thbc_pkg::PROD_W-1:0] r_p_prod [1:T];

    localparam int          NK_TOP = 2 * T + 1;
    localparam logic [63:0] RC_TOP = ((64'd1 << 32) + 64'(NK_TOP / 2)) / 64'(NK_TOP);

    logic [63:0] n_sq;
    assign n_sq = 64'(r_x_q[32]) * 64'(r_x_q[32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v[0] <= 1'b0;
        end else if (w_en) begin
            r_h_v[0] <= r_x_v[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_zero[0] <= r_x_zero[32];
            r_h_neg[0]  <= r_x_neg[32];
            r_h_ax[0]   <= r_x_q[32];
            r_h_xx[0]   <= n_sq[63:32];
            r_h_y[0]    <= thbc_pkg::Y_W'(RC_TOP);
        end
    end

    for (genvar gk = 1; gk <= T; gk++) begin : g_horner
        localparam int          NK = 2 * (T - gk) + 1;
        localparam logic [63:0] RC = ((64'd1 << 32) + 64'(NK / 2)) / 64'(NK);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p_v[gk] <= 1'b0;
                r_h_v[gk] <= 1'b0;
            end else if (w_en) begin
                r_p_v[gk] <= r_h_v[gk-1];
                r_h_v[gk] <= r_p_v[gk];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_p_zero[gk] <= r_h_zero[gk-1];
                r_p_neg[gk]  <= r_h_neg[gk-1];
                r_p_ax[gk]   <= r_h_ax[gk-1];
                r_p_xx[gk]   <= r_h_xx[gk-1];
                r_p_prod[gk] <= thbc_pkg::PROD_W'(r_h_xx[gk-1]) *
                                thbc_pkg::PROD_W'(r_h_y[gk-1]);
                r_h_zero[gk] <= r_p_zero[gk];
                r_h_neg[gk]  <= r_p_neg[gk];
                r_h_ax[gk]   <= r_p_ax[gk];
                r_h_xx[gk]   <= r_p_xx[gk];
                r_h_y[gk]    <= thbc_pkg::Y_W'(RC) +
                                r_p_prod[gk][thbc_pkg::PROD_W-1:32];
            end
        end
    end

    // Division of ln magnitude by beta, one quotient bit per stage.
    logic                       r_b_v    [0:thbc_pkg::LN_W];
    logic                       r_b_zero [0:thbc_pkg::LN_W];
    logic                       r_b_neg  [0:thbc_pkg::LN_W];
    logic [15:0]                r_b_rem  [0:thbc_pkg::LN_W];
    logic [thbc_pkg::LN_W-1:0]  r_b_nq   [0:thbc_pkg::LN_W];

    logic [thbc_pkg::PROD_W-1:0] n_lnp;
    assign n_lnp = thbc_pkg::PROD_W'(r_h_ax[T]) * thbc_pkg::PROD_W'(r_h_y[T]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v[0] <= 1'b0;
        end else if (w_en) begin
            r_b_v[0] <= r_h_v[T];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_zero[0] <= r_h_zero[T];
            r_b_neg[0]  <= r_h_neg[T];
            r_b_rem[0]  <= '0;
            r_b_nq[0]   <= {n_lnp[thbc_pkg::PROD_W-1:32], 1'b0};
        end
    end

    for (genvar gb = 0; gb < thbc_pkg::LN_W; gb++) begin : g_bdiv
        logic [16:0] n_t;
        logic        n_ge;
        assign n_t  = {r_b_rem[gb], r_b_nq[gb][thbc_pkg::LN_W-1]};
        assign n_ge = n_t >= {1'b0, n_beta};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_v[gb+1] <= 1'b0;
            end else if (w_en) begin
                r_b_v[gb+1] <= r_b_v[gb];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_b_zero[gb+1] <= r_b_zero[gb];
                r_b_neg[gb+1]  <= r_b_neg[gb];
                r_b_rem[gb+1]  <= n_ge ? 16'(n_t - {1'b0, n_beta}) : n_t[15:0];
                r_b_nq[gb+1]   <= {r_b_nq[gb][thbc_pkg::LN_W-2:0], n_ge};
            end
        end
    end

    // Reciprocal sum and kelvin division, one quotient bit per stage.
    logic                       r_c_v    [0:thbc_pkg::RN_W];
    logic                       r_c_zero [0:thbc_pkg::RN_W];
    logic                       r_c_tz   [0:thbc_pkg::RN_W];
    logic                       r_c_neg  [0:thbc_pkg::RN_W];
    logic [thbc_pkg::TM_W-1:0]  r_c_den  [0:thbc_pkg::RN_W];
    logic [thbc_pkg::TM_W-1:0]  r_c_rem  [0:thbc_pkg::RN_W];
    logic [thbc_pkg::RN_W-1:0]  r_c_nq   [0:thbc_pkg::RN_W];

    logic signed [38:0] n_lns, n_tq;
    assign n_lns = r_b_neg[thbc_pkg::LN_W] ?
                   -$signed({2'b0, r_b_nq[thbc_pkg::LN_W]}) :
                    $signed({2'b0, r_b_nq[thbc_pkg::LN_W]});
    assign n_tq  = $signed(39'(thbc_pkg::INV_T25_Q32)) + n_lns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v[0] <= 1'b0;
        end else if (w_en) begin
            r_c_v[0] <= r_b_v[thbc_pkg::LN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_zero[0] <= r_b_zero[thbc_pkg::LN_W];
            r_c_tz[0]   <= n_tq == 39'sd0;
            r_c_neg[0]  <= n_tq < 39'sd0;
            r_c_den[0]  <= thbc_pkg::TM_W'((n_tq < 39'sd0) ? -n_tq : n_tq);
            r_c_rem[0]  <= '0;
            r_c_nq[0]   <= thbc_pkg::RECIP_NUM;
        end
    end

    for (genvar gc = 0; gc < thbc_pkg::RN_W; gc++) begin : g_cdiv
        logic [thbc_pkg::TM_W:0] n_t;
        logic                    n_ge;
        assign n_t  = {r_c_rem[gc], r_c_nq[gc][thbc_pkg::RN_W-1]};
        assign n_ge = n_t >= {1'b0, r_c_den[gc]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_v[gc+1] <= 1'b0;
            end else if (w_en) begin
                r_c_v[gc+1] <= r_c_v[gc];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c_zero[gc+1] <= r_c_zero[gc];
                r_c_tz[gc+1]   <= r_c_tz[gc];
                r_c_neg[gc+1]  <= r_c_neg[gc];
                r_c_den[gc+1]  <= r_c_den[gc];
                r_c_rem[gc+1]  <= n_ge ? thbc_pkg::TM_W'(n_t - {1'b0, r_c_den[gc]})
                                       : n_t[thbc_pkg::TM_W-1:0];
                r_c_nq[gc+1]   <= {r_c_nq[gc][thbc_pkg::RN_W-2:0], n_ge};
            end
        end
    end

    // Offset, rounding shift and saturation range, then division by five.
    logic                      r_s_v, r_s_zero, r_s_tz, r_s_hi, r_s_lo;
    logic [thbc_pkg::W_W-1:0]  r_s_w;
    logic                      r_m_v, r_m_zero, r_m_tz, r_m_hi, r_m_lo;
    logic [40:0]               r_m_prod;

    logic signed [50:0] n_sq51, n_s, n_v;
    assign n_sq51 = r_c_neg[thbc_pkg::RN_W] ?
                    -$signed({2'b0, r_c_nq[thbc_pkg::RN_W]}) :
                     $signed({2'b0, r_c_nq[thbc_pkg::RN_W]});
    assign n_s    = n_sq51 - thbc_pkg::ZERO_C_OFS + thbc_pkg::HALF_DIV;
    assign n_v    = n_s >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_s_v <= r_c_v[thbc_pkg::RN_W];
            r_m_v <= r_s_v;
            r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_zero <= r_c_zero[thbc_pkg::RN_W];
            r_s_tz   <= r_c_tz[thbc_pkg::RN_W];
            r_s_hi   <= n_v >= thbc_pkg::SAT_SPAN;
            r_s_lo   <= n_v < -thbc_pkg::SAT_SPAN;
            r_s_w    <= thbc_pkg::W_W'(n_v + thbc_pkg::SAT_SPAN);

            r_m_zero <= r_s_zero;
            r_m_tz   <= r_s_tz;
            r_m_hi   <= r_s_hi;
            r_m_lo   <= r_s_lo;
            r_m_prod <= 41'(r_s_w) * 41'(thbc_pkg::DIV5_MUL);

            if (r_m_zero) begin
                r_o_c  <= 16'h0000;
                r_o_st <= thbc_pkg::ST_ZERO;
            end else if (r_m_tz || r_m_hi) begin
                r_o_c  <= 16'h7FFF;
                r_o_st <= thbc_pkg::ST_SAT;
            end else if (r_m_lo) begin
                r_o_c  <= 16'h8000;
                r_o_st <= thbc_pkg::ST_SAT;
            end else begin
                r_o_c  <= r_m_prod[39:24] ^ 16'h8000;
                r_o_st <= thbc_pkg::ST_OK;
            end
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_c;
    assign o_m_tuser  = r_o_st;

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_st == thbc_pkg::ST_ZERO |-> r_o_c == 16'h0000)
        else $error("zero-input result is not zero");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_st == thbc_pkg::ST_SAT |-> r_o_c == 16'h7FFF || r_o_c == 16'h8000)
        else $error("saturated result is not a rail value");

    a_no_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> r_o_st != 2'd3)
        else $error("undefined status code");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_o_v && !i_m_tready)
        else $error("pipeline stalled without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== tb/tb_thermistor_beta_to_celsius_unit.sv =====
// Self-checking testbench for the thermistor beta-equation Celsius converter.
module tb_thermistor_beta_to_celsius_unit;
    timeunit 1ns;
    timeprecision 1ps;

    class celsius_scoreboard;
        logic [15:0] ref_res;
        logic [15:0] beta;
        logic [17:0] expected_q[$];
        int          errors;

        function new();
            ref_res = 16'd120;
            beta    = 16'd3910;
            errors  = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == thbc_pkg::CFG_REF_RES) begin
                ref_res = val;
            end else begin
                beta = val;
            end
        endfunction

        function longint unsigned recip(longint unsigned n);
            return ((64'd1 << 32) + n / 2) / n;
        endfunction

        function longint unsigned mulq(longint unsigned a, longint unsigned b);
            return a * (b >> 32) + ((a * (b & 64'hFFFF_FFFF)) >> 32);
        endfunction

        // Returns {status, celsius}.
        function logic [17:0] convert(logic [23:0] r);
            longint unsigned rref, bk, sref, den, numag, ax, xx, y, lnmag, nk;
            bit neg;
            longint tq, s, c;
            logic [1:0] st;
            rref = (ref_res == 0) ? 1 : ref_res;
            bk   = (beta == 0) ? 1 : beta;
            if (r == 0) return {thbc_pkg::ST_ZERO, 16'd0};
            sref  = rref << 8;
            den   = r + sref;
            neg   = r < sref;
            numag = neg ? sref - r : r - sref;
            ax    = (numag << 32) / den;
            xx    = (ax * ax) >> 32;
            nk    = 2 * thbc_pkg::SERIES_TERMS + 1;
            y     = recip(nk);
            for (int k = thbc_pkg::SERIES_TERMS; k > 0; k--) begin
                nk -= 2;
                y = recip(nk) + mulq(xx, y);
            end
            lnmag = (2 * mulq(ax, y)) / bk;
            tq = longint'(thbc_pkg::INV_T25_Q32) +
                 (neg ? -longint'(lnmag) : longint'(lnmag));
            if (tq == 0) return {thbc_pkg::ST_SAT, 16'h7FFF};
            if (tq > 0) begin
                s = longint'((64'd5 << 46) / longint'(tq)) - 22376448;
            end else begin
                s = -longint'((64'd5 << 46) / longint'(-tq)) - 22376448;
            end
            s = s + 640;
            c = (s >= 0) ? s / 1280 : -(((-s) + 1279) / 1280);
            st = thbc_pkg::ST_OK;
            if (c > 32767) begin
                c = 32767;
                st = thbc_pkg::ST_SAT;
            end else if (c < -32768) begin
                c = -32768;
                st = thbc_pkg::ST_SAT;
            end
            return {st, c[15:0]};
        endfunction

        function void note_input(logic [23:0] r);
            expected_q.push_back(convert(r));
        endfunction

        function void check_result(logic [15:0] cel, logic [1:0] st);
            logic [17:0] e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result celsius=%0d status=%0d", $time,
                         $signed(cel), st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (e[15:0] !== cel) begin
                $display("%0t: celsius expected %0d actual %0d", $time,
                         $signed(e[15:0]), $signed(cel));
                errors++;
            end
            if (e[17:16] !== st) begin
                $display("%0t: status expected %0d actual %0d", $time, e[17:16], st);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    celsius_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    thermistor_beta_to_celsius_unit uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
        if (quiet_cycles > 5000) begin
            $display("tb_thermistor_beta_to_celsius_unit NOT OK");
            $finish;
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_m_tready = calm ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_regs(logic [15:0] rref, logic [15:0] bk);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (160) @(posedge i_clk);
        write_reg(thbc_pkg::CFG_REF_RES, rref);
        write_reg(thbc_pkg::CFG_BETA, bk);
    endtask

    task automatic send_item(logic [23:0] r);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 8) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = r;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(r);
    endtask

    function automatic logic [23:0] pick_resistance();
        logic [47:0] base;
        case ($urandom_range(9))
            0, 1, 2: return 24'($urandom());
            3:       return 24'($urandom_range(255));
            4:       return 24'hFFFFFF - 24'($urandom_range(255));
            default: begin
                base = 48'((sb.ref_res == 0) ? 16'd1 : sb.ref_res) << 8;
                base = (base * 48'($urandom_range(400, 1))) / 48'd40 +
                       48'($urandom_range(63));
                return (base > 48'hFFFFFF) ? 24'hFFFFFF : base[23:0];
            end
        endcase
    endfunction

    initial begin
        logic [15:0] rr;
        logic [15:0] bb;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(24'd0);
        send_item(24'd1);
        send_item(24'hFFFFFF);
        send_item(24'd30720);
        send_item(24'd30719);
        send_item(24'd30721);
        set_regs(16'd1, 16'd1);
        send_item(24'd256);
        send_item(24'd1);
        send_item(24'hFFFFFF);
        send_item(24'd0);
        set_regs(16'd65535, 16'd65535);
        send_item(24'hFFFF00);
        send_item(24'd1);
        send_item(24'hFFFFFF);
        set_regs(16'd0, 16'd0);
        send_item(24'd256);
        send_item(24'd1);
        send_item(24'hFFFFFF);
        set_regs(16'd65535, 16'd1);
        send_item(24'd1);
        send_item(24'd200);
        send_item(24'hFFFFFF);
        set_regs(16'd1, 16'd65535);
        send_item(24'd1);
        send_item(24'hFFFFFF);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin rr = 16'd120;   bb = 16'd3910;  end
                1: begin rr = 16'd65535; bb = 16'd65535; end
                2: begin rr = 16'd1;     bb = 16'd1;     end
                default: begin rr = 16'($urandom()); bb = 16'($urandom()); end
            endcase
            if (ph == 5) bb = 16'($urandom_range(40));
            set_regs(rr, bb);
            calm = (ph == 3);
            if (ph == 1) hold_req = 1'b1;
            repeat (66) send_item(pick_resistance());
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_thermistor_beta_to_celsius_unit OK");
        end else begin
            $display("tb_thermistor_beta_to_celsius_unit NOT OK");
        end
        $finish;
    end
endmodule
